FILE: rtl/gpf_pkg.sv
// gravity pair force: shared widths, limits and payload types
`default_nettype none

package gpf_pkg;

  // geometry and field widths
  localparam int NDIM   = 3;
  localparam int POS_W  = 32;
  localparam int MASS_W = 32;
  localparam int IDX_W  = 16;
  localparam int FRC_W  = 64;

  // internal arithmetic widths
  localparam int LIMB_W = 32;
  localparam int DIF_W  = POS_W + 1;
  localparam int SQ_W   = 2 * DIF_W - 1;
  localparam int R_W    = SQ_W + 1;
  localparam int MM_W   = 2 * MASS_W;
  localparam int R2_W   = 2 * R_W;
  localparam int R3_W   = 3 * R_W;
  localparam int P_W    = DIF_W + MM_W;
  localparam int P2_W   = 2 * P_W;
  localparam int Q_W    = FRC_W;
  localparam int N_W    = P2_W + Q_W;
  localparam int Y_W    = (N_W + R3_W) / 2;

  // saturation limits of the force magnitude
  localparam logic [FRC_W-1:0] CAP_POS = {1'b0, {(FRC_W-1){1'b1}}};
  localparam logic [FRC_W-1:0] CAP_NEG = {1'b1, {(FRC_W-1){1'b0}}};

  // per request flags and indices that travel the whole pipe
  typedef struct packed {
    logic [NDIM-1:0]  dpos;
    logic             wi;
    logic             wj;
    logic [IDX_W-1:0] idx_i;
    logic [IDX_W-1:0] idx_j;
    logic             coin;
  } gpf_side_t;

  // payload around the r*r multiplier
  typedef struct packed {
    gpf_side_t                   side;
    logic [NDIM-1:0][DIF_W-1:0]  dabs;
    logic [MM_W-1:0]             mm;
    logic [R_W-1:0]              r;
  } gpf_m1_t;

  // payload around the r^2*r multiplier
  typedef struct packed {
    gpf_side_t                   side;
    logic [NDIM-1:0][DIF_W-1:0]  dabs;
    logic [MM_W-1:0]             mm;
  } gpf_m2_t;

  // payload around the numerator multipliers
  typedef struct packed {
    gpf_side_t        side;
    logic [R3_W-1:0]  r3;
  } gpf_m3_t;

endpackage

`default_nettype wire

FILE: rtl/gpf_mul.sv
// limb serial pipelined multiplier, one 32x32 partial product per lane per stage
`default_nettype none

module gpf_mul import gpf_pkg::*; #(
  parameter int LANES = 1,
  parameter int WA    = 32,
  parameter int WB    = 32,
  parameter int WP    = 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          adv,
  input  wire logic                          in_valid,
  input  wire logic [LANES-1:0][WA-1:0]      a,
  input  wire logic [LANES-1:0][WB-1:0]      b,
  input  wire logic [WP-1:0]                 in_pl,
  output logic                               out_valid,
  output logic      [LANES-1:0][WA+WB-1:0]   prod,
  output logic      [WP-1:0]                 out_pl
);

  localparam int NA = (WA + LIMB_W - 1) / LIMB_W;
  localparam int NB = (WB + LIMB_W - 1) / LIMB_W;
  localparam int NS = NA * NB;
  localparam int AW = NA * LIMB_W;
  localparam int BW = NB * LIMB_W;
  localparam int WR = WA + WB;

  logic                           v_q   [NS];
  logic [LANES-1:0][AW-1:0]       a_q   [NS];
  logic [LANES-1:0][BW-1:0]       b_q   [NS];
  logic [LANES-1:0][WR-1:0]       acc_q [NS];
  logic [WP-1:0]                  pl_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int LI = s / NB;
    localparam int LJ = s % NB;

    logic                        v_in;
    logic [LANES-1:0][AW-1:0]    a_in;
    logic [LANES-1:0][BW-1:0]    b_in;
    logic [LANES-1:0][WR-1:0]    acc_in;
    logic [WP-1:0]               pl_in;
    logic [2*LIMB_W-1:0]         pp     [LANES];
    logic [LANES-1:0][WR-1:0]    acc_nx;

    // stage input: ports for the first stage, previous stage otherwise
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          a_in[l]   = AW'(a[l]);
          b_in[l]   = BW'(b[l]);
          acc_in[l] = '0;
        end
      end
      assign v_in  = in_valid;
      assign pl_in = in_pl;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign a_in   = a_q[s-1];
      assign b_in   = b_q[s-1];
      assign acc_in = acc_q[s-1];
      assign pl_in  = pl_q[s-1];
    end

    // one partial product per lane, shifted into place and accumulated
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        pp[l]     = a_in[l][LI*LIMB_W +: LIMB_W] * b_in[l][LJ*LIMB_W +: LIMB_W];
        acc_nx[l] = acc_in[l] + (WR'(pp[l]) << (LIMB_W * (LI + LJ)));
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (adv) begin
        v_q[s] <= v_in;
      end
    end

    // stage data
    always_ff @(posedge clk) begin
      if (adv) begin
        a_q[s]   <= a_in;
        b_q[s]   <= b_in;
        acc_q[s] <= acc_nx;
        pl_q[s]  <= pl_in;
      end
    end
  end

  assign out_valid = v_q[NS-1];
  assign prod      = acc_q[NS-1];
  assign out_pl    = pl_q[NS-1];

endmodule

`default_nettype wire

FILE: rtl/gpf_root.sv
// pipelined bit recurrence for floor(sqrt(n / r3)), one quotient bit per stage
`default_nettype none

module gpf_root import gpf_pkg::*; #(
  parameter int LANES = NDIM,
  parameter int WP    = 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         adv,
  input  wire logic                         in_valid,
  input  wire logic [LANES-1:0][P2_W-1:0]   p2,
  input  wire logic [R3_W-1:0]              r3,
  input  wire logic [WP-1:0]                in_pl,
  output logic                              out_valid,
  output logic      [LANES-1:0][Q_W-1:0]    q,
  output logic      [LANES-1:0]             big,
  output logic      [WP-1:0]                out_pl
);

  localparam int NS    = Q_W;
  localparam int T_W   = R3_W + 2 * Q_W - 1;
  localparam int BIG_W = R3_W + 2 * Q_W;

  logic                          v_q   [NS];
  logic [R3_W-1:0]               r_q   [NS];
  logic [LANES-1:0][N_W-1:0]     rem_q [NS];
  logic [LANES-1:0][Y_W-1:0]     y_q   [NS];
  logic [LANES-1:0][Q_W-1:0]     q_q   [NS];
  logic [LANES-1:0]              big_q [NS];
  logic [WP-1:0]                 pl_q  [NS];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    localparam int B = NS - 1 - s;

    logic                        v_in;
    logic [R3_W-1:0]             r_in;
    logic [LANES-1:0][N_W-1:0]   rem_in;
    logic [LANES-1:0][Y_W-1:0]   y_in;
    logic [LANES-1:0][Q_W-1:0]   q_in;
    logic [LANES-1:0]            big_in;
    logic [WP-1:0]               pl_in;
    logic [LANES-1:0][T_W-1:0]   t;
    logic [LANES-1:0]            fit;
    logic [LANES-1:0][N_W-1:0]   rem_nx;
    logic [LANES-1:0][Y_W-1:0]   y_nx;
    logic [LANES-1:0][Q_W-1:0]   q_nx;

    // first stage: remainder starts at p2 * 2^64, overflow check against 2^128 * r3
    if (s == 0) begin : g_first
      always_comb begin
        for (int l = 0; l < LANES; l++) begin
          rem_in[l] = {p2[l], {Q_W{1'b0}}};
          y_in[l]   = '0;
          q_in[l]   = '0;
          big_in[l] = (BIG_W'(r3) << (2 * Q_W)) <= BIG_W'(rem_in[l]);
        end
      end
      assign v_in  = in_valid;
      assign r_in  = r3;
      assign pl_in = in_pl;
    end else begin : g_next
      assign v_in   = v_q[s-1];
      assign r_in   = r_q[s-1];
      assign rem_in = rem_q[s-1];
      assign y_in   = y_q[s-1];
      assign q_in   = q_q[s-1];
      assign big_in = big_q[s-1];
      assign pl_in  = pl_q[s-1];
    end

    // try bit B: (q + 2^B)^2 r3 - q^2 r3 = 2^(B+1) q r3 + 2^(2B) r3
    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        t[l]      = (T_W'(y_in[l]) << (B + 1)) + (T_W'(r_in) << (2 * B));
        fit[l]    = t[l] <= T_W'(rem_in[l]);
        rem_nx[l] = fit[l] ? (rem_in[l] - N_W'(t[l])) : rem_in[l];
        y_nx[l]   = fit[l] ? (y_in[l] + Y_W'(T_W'(r_in) << B)) : y_in[l];
        q_nx[l]   = fit[l] ? (q_in[l] | (Q_W'(1) << B)) : q_in[l];
      end
    end

    // stage valid
    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[s] <= 1'b0;
      end else if (adv) begin
        v_q[s] <= v_in;
      end
    end

    // stage data
    always_ff @(posedge clk) begin
      if (adv) begin
        r_q[s]   <= r_in;
        rem_q[s] <= rem_nx;
        y_q[s]   <= y_nx;
        q_q[s]   <= q_nx;
        big_q[s] <= big_in;
        pl_q[s]  <= pl_in;
      end
    end
  end

  assign out_valid = v_q[NS-1];
  assign q         = q_q[NS-1];
  assign big       = big_q[NS-1];
  assign out_pl    = pl_q[NS-1];

endmodule

`default_nettype wire

FILE: rtl/gravity_pair_force_top.sv
// gravity pair force: top level with input skid, front end, multipliers, root and output stage
//
// One request carries two 3D positions (signed Q16.16), two masses (unsigned Q16.16),
// two particle indices and two write enables. One result comes back per request with
// the force increments for i and j (signed Q32.32, saturated), the copied indices, a
// coincident flag and a saturated flag. Results leave in request order.
// Both channels are valid/ready. A request is taken when in_valid and in_ready are
// high, a result when out_valid and out_ready are high.
// From request to result a request passes two front stages, 44 limb multiplier
// stages for r^3 and the squared numerator, the 64 step root recurrence (one quotient
// bit per stage) and the output register.
// Throughput is one request per cycle while out_ready is high.
// When the receiver stalls, the whole pipe holds; one more request is caught in the
// skid register, then in_ready drops until the pipe moves again.
// Reset clears all valid bits and the skid full flag; no results are pending after it.
`default_nettype none

module gravity_pair_force_top import gpf_pkg::*; (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     in_valid,
  output logic                          in_ready,
  input  wire logic signed [POS_W-1:0]  pos_i_x,
  input  wire logic signed [POS_W-1:0]  pos_i_y,
  input  wire logic signed [POS_W-1:0]  pos_i_z,
  input  wire logic signed [POS_W-1:0]  pos_j_x,
  input  wire logic signed [POS_W-1:0]  pos_j_y,
  input  wire logic signed [POS_W-1:0]  pos_j_z,
  input  wire logic [MASS_W-1:0]        mass_i,
  input  wire logic [MASS_W-1:0]        mass_j,
  input  wire logic [IDX_W-1:0]         index_i,
  input  wire logic [IDX_W-1:0]         index_j,
  input  wire logic                     write_i,
  input  wire logic                     write_j,
  output logic                          out_valid,
  input  wire logic                     out_ready,
  output logic signed [FRC_W-1:0]       force_i_x,
  output logic signed [FRC_W-1:0]       force_i_y,
  output logic signed [FRC_W-1:0]       force_i_z,
  output logic signed [FRC_W-1:0]       force_j_x,
  output logic signed [FRC_W-1:0]       force_j_y,
  output logic signed [FRC_W-1:0]       force_j_z,
  output logic [IDX_W-1:0]              out_index_i,
  output logic [IDX_W-1:0]              out_index_j,
  output logic                          coincident,
  output logic                          saturated
);

  typedef struct packed {
    logic [NDIM-1:0][POS_W-1:0] pi;
    logic [NDIM-1:0][POS_W-1:0] pj;
    logic [MASS_W-1:0]          mi;
    logic [MASS_W-1:0]          mj;
    logic [IDX_W-1:0]           idx_i;
    logic [IDX_W-1:0]           idx_j;
    logic                       wi;
    logic                       wj;
  } req_t;

  logic   adv;
  req_t   in_req;
  req_t   skid_q;
  logic   skid_full;
  logic   src_valid;
  req_t   src;

  // whole pipe moves when the output register is empty or being taken
  assign adv      = !out_valid || out_ready;
  assign in_ready = !skid_full;

  assign in_req.pi    = {pos_i_z, pos_i_y, pos_i_x};
  assign in_req.pj    = {pos_j_z, pos_j_y, pos_j_x};
  assign in_req.mi    = mass_i;
  assign in_req.mj    = mass_j;
  assign in_req.idx_i = index_i;
  assign in_req.idx_j = index_j;
  assign in_req.wi    = write_i;
  assign in_req.wj    = write_j;

  // skid register catches one request while the pipe is held
  always_ff @(posedge clk) begin
    if (rst) begin
      skid_full <= 1'b0;
    end else if (adv) begin
      skid_full <= 1'b0;
    end else if (in_valid && in_ready) begin
      skid_full <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!adv && in_valid && !skid_full) begin
      skid_q <= in_req;
    end
  end

  assign src_valid = skid_full || in_valid;
  assign src       = skid_full ? skid_q : in_req;

  // front stage 1: differences, magnitudes, squares and mass product
  logic signed [NDIM-1:0][DIF_W-1:0] d;
  logic [NDIM-1:0][DIF_W-1:0]        dabs;
  logic [NDIM-1:0][SQ_W-1:0]         sq;
  logic [MM_W-1:0]                   mm;
  gpf_side_t                         side;

  always_comb begin
    for (int k = 0; k < NDIM; k++) begin
      d[k]    = {src.pi[k][POS_W-1], src.pi[k]} - {src.pj[k][POS_W-1], src.pj[k]};
      dabs[k] = d[k][DIF_W-1] ? (~d[k] + DIF_W'(1)) : d[k];
      sq[k]   = dabs[k] * dabs[k];
      side.dpos[k] = !d[k][DIF_W-1] && (d[k] != '0);
    end
    mm         = src.mi * src.mj;
    side.wi    = src.wi;
    side.wj    = src.wj;
    side.idx_i = src.idx_i;
    side.idx_j = src.idx_j;
    side.coin  = (d == '0);
  end

  logic                         f1_v;
  gpf_side_t                    f1_side;
  logic [NDIM-1:0][DIF_W-1:0]   f1_dabs;
  logic [NDIM-1:0][SQ_W-1:0]    f1_sq;
  logic [MM_W-1:0]              f1_mm;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_v <= 1'b0;
    end else if (adv) begin
      f1_v <= src_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_side <= side;
      f1_dabs <= dabs;
      f1_sq   <= sq;
      f1_mm   <= mm;
    end
  end

  // front stage 2: squared distance
  logic      f2_v;
  gpf_m1_t   f2_pl;

  always_ff @(posedge clk) begin
    if (rst) begin
      f2_v <= 1'b0;
    end else if (adv) begin
      f2_v <= f1_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f2_pl.side <= f1_side;
      f2_pl.dabs <= f1_dabs;
      f2_pl.mm   <= f1_mm;
      f2_pl.r    <= R_W'(f1_sq[0]) + R_W'(f1_sq[1]) + R_W'(f1_sq[2]);
    end
  end

  // r^2
  logic             m1_v;
  logic [R2_W-1:0]  m1_prod;
  gpf_m1_t          m1_pl;

  gpf_mul #(
    .LANES (1),
    .WA    (R_W),
    .WB    (R_W),
    .WP    ($bits(gpf_m1_t))
  ) u_mul_r2 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f2_v),
    .a         (f2_pl.r),
    .b         (f2_pl.r),
    .in_pl     (f2_pl),
    .out_valid (m1_v),
    .prod      (m1_prod),
    .out_pl    (m1_pl)
  );

  // r^3
  logic             m2_v;
  logic [R3_W-1:0]  m2_prod;
  gpf_m2_t          m2_in;
  gpf_m2_t          m2_pl;

  assign m2_in.side = m1_pl.side;
  assign m2_in.dabs = m1_pl.dabs;
  assign m2_in.mm   = m1_pl.mm;

  gpf_mul #(
    .LANES (1),
    .WA    (R2_W),
    .WB    (R_W),
    .WP    ($bits(gpf_m2_t))
  ) u_mul_r3 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m1_v),
    .a         (m1_prod),
    .b         (m1_pl.r),
    .in_pl     (m2_in),
    .out_valid (m2_v),
    .prod      (m2_prod),
    .out_pl    (m2_pl)
  );

  // numerator |d| * mi * mj per axis
  logic                        m3_v;
  logic [NDIM-1:0][MM_W-1:0]   m3_b;
  logic [NDIM-1:0][P_W-1:0]    m3_prod;
  gpf_m3_t                     m3_in;
  gpf_m3_t                     m3_pl;

  assign m3_b        = {NDIM{m2_pl.mm}};
  assign m3_in.side  = m2_pl.side;
  assign m3_in.r3    = m2_prod;

  gpf_mul #(
    .LANES (NDIM),
    .WA    (DIF_W),
    .WB    (MM_W),
    .WP    ($bits(gpf_m3_t))
  ) u_mul_num (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m2_v),
    .a         (m2_pl.dabs),
    .b         (m3_b),
    .in_pl     (m3_in),
    .out_valid (m3_v),
    .prod      (m3_prod),
    .out_pl    (m3_pl)
  );

  // numerator squared
  logic                        m4_v;
  logic [NDIM-1:0][P2_W-1:0]   m4_prod;
  gpf_m3_t                     m4_pl;

  gpf_mul #(
    .LANES (NDIM),
    .WA    (P_W),
    .WB    (P_W),
    .WP    ($bits(gpf_m3_t))
  ) u_mul_num2 (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m3_v),
    .a         (m3_prod),
    .b         (m3_prod),
    .in_pl     (m3_pl),
    .out_valid (m4_v),
    .prod      (m4_prod),
    .out_pl    (m4_pl)
  );

  // quotient magnitude per axis
  logic                        rt_v;
  logic [NDIM-1:0][Q_W-1:0]    rt_q;
  logic [NDIM-1:0]             rt_big;
  gpf_side_t                   rt_side;

  gpf_root #(
    .LANES (NDIM),
    .WP    ($bits(gpf_side_t))
  ) u_root (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (m4_v),
    .p2        (m4_prod),
    .r3        (m4_pl.r3),
    .in_pl     (m4_pl.side),
    .out_valid (rt_v),
    .q         (rt_q),
    .big       (rt_big),
    .out_pl    (rt_side)
  );

  // signs, saturation and write enables
  logic [NDIM-1:0][FRC_W-1:0]  fi;
  logic [NDIM-1:0][FRC_W-1:0]  fj;
  logic                        sat;

  always_comb begin
    logic [FRC_W-1:0] cap_i;
    logic [FRC_W-1:0] cap_j;
    logic [FRC_W-1:0] mag_i;
    logic [FRC_W-1:0] mag_j;
    logic             clip_i;
    logic             clip_j;
    logic             en_i;
    logic             en_j;
    sat  = 1'b0;
    en_i = rt_side.wi && !rt_side.coin;
    en_j = rt_side.wj && !rt_side.coin;
    for (int k = 0; k < NDIM; k++) begin
      cap_i  = rt_side.dpos[k] ? CAP_NEG : CAP_POS;
      cap_j  = rt_side.dpos[k] ? CAP_POS : CAP_NEG;
      clip_i = rt_big[k] || (rt_q[k] > cap_i);
      clip_j = rt_big[k] || (rt_q[k] > cap_j);
      mag_i  = clip_i ? cap_i : rt_q[k];
      mag_j  = clip_j ? cap_j : rt_q[k];
      fi[k]  = !en_i ? '0 : (rt_side.dpos[k] ? (~mag_i + FRC_W'(1)) : mag_i);
      fj[k]  = !en_j ? '0 : (rt_side.dpos[k] ? mag_j : (~mag_j + FRC_W'(1)));
      sat    = sat || (en_i && clip_i) || (en_j && clip_j);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= rt_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      force_i_x   <= fi[0];
      force_i_y   <= fi[1];
      force_i_z   <= fi[2];
      force_j_x   <= fj[0];
      force_j_y   <= fj[1];
      force_j_z   <= fj[2];
      out_index_i <= rt_side.idx_i;
      out_index_j <= rt_side.idx_j;
      coincident  <= rt_side.coin;
      saturated   <= sat;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/gpf_check.sv
// gravity pair force: port level checks and their binding to the top level
`default_nettype none

module gpf_check import gpf_pkg::*; (
  input wire logic                     clk,
  input wire logic                     rst,
  input wire logic                     in_valid,
  input wire logic                     in_ready,
  input wire logic signed [POS_W-1:0]  pos_i_x,
  input wire logic signed [POS_W-1:0]  pos_i_y,
  input wire logic signed [POS_W-1:0]  pos_i_z,
  input wire logic signed [POS_W-1:0]  pos_j_x,
  input wire logic signed [POS_W-1:0]  pos_j_y,
  input wire logic signed [POS_W-1:0]  pos_j_z,
  input wire logic [MASS_W-1:0]        mass_i,
  input wire logic [MASS_W-1:0]        mass_j,
  input wire logic [IDX_W-1:0]         index_i,
  input wire logic [IDX_W-1:0]         index_j,
  input wire logic                     write_i,
  input wire logic                     write_j,
  input wire logic                     out_valid,
  input wire logic                     out_ready,
  input wire logic signed [FRC_W-1:0]  force_i_x,
  input wire logic signed [FRC_W-1:0]  force_i_y,
  input wire logic signed [FRC_W-1:0]  force_i_z,
  input wire logic signed [FRC_W-1:0]  force_j_x,
  input wire logic signed [FRC_W-1:0]  force_j_y,
  input wire logic signed [FRC_W-1:0]  force_j_z,
  input wire logic [IDX_W-1:0]         out_index_i,
  input wire logic [IDX_W-1:0]         out_index_j,
  input wire logic                     coincident,
  input wire logic                     saturated
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(force_i_x) && $stable(force_j_z)
      && $stable(out_index_i) && $stable(saturated))
    else $error("result changed while stalled");

  // coincident pairs carry no force and never saturate
  a_coin_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && coincident |-> force_i_x == '0 && force_i_y == '0 && force_i_z == '0
      && force_j_x == '0 && force_j_y == '0 && force_j_z == '0 && !saturated)
    else $error("coincident result with force");

  // a saturated result shows at least one component at a limit
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |->
      force_i_x == CAP_POS || force_i_x == CAP_NEG || force_i_y == CAP_POS
      || force_i_y == CAP_NEG || force_i_z == CAP_POS || force_i_z == CAP_NEG
      || force_j_x == CAP_POS || force_j_x == CAP_NEG || force_j_y == CAP_POS
      || force_j_y == CAP_NEG || force_j_z == CAP_POS || force_j_z == CAP_NEG)
    else $error("saturated flag without a clipped component");

  // input side only backs up after an output stall
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("in_ready low without an output stall");

endmodule

bind gravity_pair_force_top gpf_check u_check (.*);

`default_nettype wire
